[design/cmvr_pkg.sv]
// Shared types, constants and register codes for the color mask run centroid block.
package cmvr_pkg;

   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int MAX_HEIGHT_DEF    = 1024;
   localparam int HALF_SPAN_DEF     = 6;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int PIX_W       = 8;
   localparam int WIDTH_CFG_W = 11;
   localparam int TALLY_W     = 21;
   localparam int SUM_W       = 30;
   localparam int COORD_W     = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_LUMA_LOW       = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LUMA_HIGH      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_DIFF_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_DIFF_HIGH = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_DIFF_LOW   = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_DIFF_HIGH  = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = CSR_INDEX_W'(6);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_COUNT      = CSR_INDEX_W'(7);

   localparam logic [PIX_W-1:0]       RST_LUMA_LOW       = PIX_W'(50);
   localparam logic [PIX_W-1:0]       RST_LUMA_HIGH      = PIX_W'(150);
   localparam logic [PIX_W-1:0]       RST_BLUE_DIFF_LOW  = PIX_W'(150);
   localparam logic [PIX_W-1:0]       RST_BLUE_DIFF_HIGH = PIX_W'(250);
   localparam logic [PIX_W-1:0]       RST_RED_DIFF_LOW   = PIX_W'(50);
   localparam logic [PIX_W-1:0]       RST_RED_DIFF_HIGH  = PIX_W'(150);
   localparam logic [WIDTH_CFG_W-1:0] RST_IMAGE_WIDTH    = WIDTH_CFG_W'(1024);
   localparam logic [TALLY_W-1:0]     RST_MIN_COUNT      = TALLY_W'(1);

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] blue_diff;
      logic [PIX_W-1:0] red_diff;
      logic             frame_end;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] centroid_x;
      logic [COORD_W-1:0] centroid_y;
      logic [TALLY_W-1:0] kept_count;
      logic               centroid_valid;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma_low;
      logic [PIX_W-1:0] luma_high;
      logic [PIX_W-1:0] blue_diff_low;
      logic [PIX_W-1:0] blue_diff_high;
      logic [PIX_W-1:0] red_diff_low;
      logic [PIX_W-1:0] red_diff_high;
   } window_type;

endpackage

[design/cmvr_ram.sv]
// Generic single write port RAM with one registered read port.
module cmvr_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read at the same edge as a write to that address returns the old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/cmvr_queue.sv]
// Short first-in first-out queue between the pixel front end and the back end.
module cmvr_queue #(
   parameter int WIDTH = 24,
   parameter int DEPTH = cmvr_pkg::QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entries_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

[design/cmvr_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
module cmvr_divider #(
   parameter int NUM_W = 38,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The numerator shifts out of the top while quotient bits enter below.
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[design/cmvr_front.sv]
// Pixel front end: takes input words, tracks raster position and marks pixels.
module cmvr_front #(
   parameter int MAX_WIDTH  = cmvr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cmvr_pkg::MAX_HEIGHT_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT),
   localparam int REC_W = COL_W + ROW_W + 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cmvr_pkg::req_type                   req_data,
   input  cmvr_pkg::window_type                win,
   input  logic [cmvr_pkg::WIDTH_CFG_W-1:0]    image_width,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [REC_W-1:0]                    q_rec
);

   localparam int CNT_W  = COL_W + 1;
   localparam int WCMP_W = (CNT_W > cmvr_pkg::WIDTH_CFG_W) ? CNT_W : cmvr_pkg::WIDTH_CFG_W;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_cur;
   logic [ROW_W-1:0]  row_cur;
   logic [CNT_W-1:0]  col_inc;
   logic [WCMP_W-1:0] w_raw;
   logic [CNT_W-1:0]  w_eff;
   logic              accept;
   logic              marked;

   always_comb begin
      w_raw = WCMP_W'(image_width);
      if (w_raw == '0) begin
         w_eff = CNT_W'(1);
      end else if (w_raw > WCMP_W'(MAX_WIDTH)) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = w_raw[CNT_W-1:0];
      end

      // A width lowered in the middle of a row sends the pixel to the next row.
      if ({1'b0, col_ff} >= w_eff) begin
         col_cur = '0;
         row_cur = (row_ff < ROW_W'(MAX_HEIGHT - 1)) ? row_ff + ROW_W'(1) : row_ff;
      end else begin
         col_cur = col_ff;
         row_cur = row_ff;
      end

      col_inc = {1'b0, col_cur} + CNT_W'(1);
      if (req_data.frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_cur < ROW_W'(MAX_HEIGHT - 1)) ? row_cur + ROW_W'(1) : row_cur;
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end

      marked = (req_data.luma > win.luma_low) && (req_data.luma < win.luma_high) &&
               (req_data.blue_diff > win.blue_diff_low) &&
               (req_data.blue_diff < win.blue_diff_high) &&
               (req_data.red_diff > win.red_diff_low) &&
               (req_data.red_diff < win.red_diff_high);
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;
   assign q_rec     = {col_cur, row_cur, marked, req_data.frame_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[design/cmvr_back.sv]
// Back end: column run counters, accumulators, centroid division and result register.
module cmvr_back #(
   parameter int MAX_WIDTH     = cmvr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = cmvr_pkg::MAX_HEIGHT_DEF,
   parameter int HALF_SPAN     = cmvr_pkg::HALF_SPAN_DEF,
   parameter int FRACTION_BITS = cmvr_pkg::FRACTION_BITS_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT),
   localparam int REC_W = COL_W + ROW_W + 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  logic [REC_W-1:0]                  q_rec,
   output logic                              q_pop,
   input  logic [cmvr_pkg::TALLY_W-1:0]      min_pixel_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cmvr_pkg::rsp_type                 rsp_data
);

   localparam int SPAN    = 2 * HALF_SPAN + 1;
   localparam int RUN_W   = $clog2(SPAN + 1);
   localparam int CNT_W   = COL_W + 1;
   localparam int SUM_W   = cmvr_pkg::SUM_W;
   localparam int TALLY_W = cmvr_pkg::TALLY_W;
   localparam int COORD_W = cmvr_pkg::COORD_W;
   localparam int NUM_W   = SUM_W + FRACTION_BITS;
   localparam logic [NUM_W-1:0] COORD_LIM = NUM_W'({COORD_W{1'b1}});

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   state_type         state_ff, state_in;

   // Stage holding a popped pixel while its run counter is read.
   logic              s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_marked_ff;
   logic              s1_fe_ff;

   // Last run written, for a read that raced its write.
   logic              last_ok_ff, last_ok_in;
   logic [COL_W-1:0]  last_col_ff;
   logic [RUN_W-1:0]  last_run_ff;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_col_ff, sum_col_in, sum_col_next;
   logic [SUM_W-1:0]  sum_row_ff, sum_row_in, sum_row_next;
   logic [TALLY_W-1:0] tally_ff, tally_in, tally_next;

   logic              res_valid_ff, res_valid_in;
   logic [TALLY_W-1:0] res_count_ff, res_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cmvr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [RUN_W-1:0]  ram_rdata;
   logic [RUN_W-1:0]  stored;
   logic [RUN_W-1:0]  run_new;
   logic [CNT_W-1:0]  col_next;
   logic [SUM_W:0]    col_add;
   logic [SUM_W:0]    row_add;
   logic [ROW_W-1:0]  row_off;
   logic              process;
   logic              kept;
   logic              div_start;
   logic              busy_x, busy_y;
   logic [NUM_W-1:0]  quo_x, quo_y;
   logic              load;

   assign q_pop   = (state_ff == ST_RUN) && !q_empty && !(s1_valid_ff && s1_fe_ff);
   assign process = s1_valid_ff;

   cmvr_ram #(
      .WIDTH (RUN_W),
      .DEPTH (MAX_WIDTH)
   ) u_run_ram (
      .clock (clock),
      .we    (process),
      .waddr (s1_col_ff),
      .wdata (run_new),
      .re    (q_pop),
      .raddr (q_rec[REC_W-1 -: COL_W]),
      .rdata (ram_rdata)
   );

   always_comb begin
      // Columns not yet visited in this frame read as an empty run.
      if (last_ok_ff && (last_col_ff == s1_col_ff)) begin
         stored = last_run_ff;
      end else if ({1'b0, s1_col_ff} < fill_ff) begin
         stored = ram_rdata;
      end else begin
         stored = '0;
      end

      if (!s1_marked_ff) begin
         run_new = '0;
      end else if (stored < RUN_W'(SPAN)) begin
         run_new = stored + RUN_W'(1);
      end else begin
         run_new = RUN_W'(SPAN);
      end

      kept    = process && (run_new == RUN_W'(SPAN)) && (s1_row_ff >= ROW_W'(HALF_SPAN));
      row_off = s1_row_ff - ROW_W'(HALF_SPAN);
      col_add = {1'b0, sum_col_ff} + (SUM_W + 1)'(s1_col_ff);
      row_add = {1'b0, sum_row_ff} + (SUM_W + 1)'(row_off);

      sum_col_next = sum_col_ff;
      sum_row_next = sum_row_ff;
      tally_next   = tally_ff;
      if (kept) begin
         sum_col_next = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
         sum_row_next = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
         tally_next   = (tally_ff == '1) ? tally_ff : tally_ff + TALLY_W'(1);
      end

      div_start = process && s1_fe_ff;
      col_next  = {1'b0, s1_col_ff} + CNT_W'(1);
   end

   cmvr_divider #(
      .NUM_W (NUM_W),
      .DEN_W (TALLY_W)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (NUM_W'(sum_col_next) << FRACTION_BITS),
      .denom    (tally_next),
      .busy     (busy_x),
      .quotient (quo_x)
   );

   cmvr_divider #(
      .NUM_W (NUM_W),
      .DEN_W (TALLY_W)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (NUM_W'(sum_row_next) << FRACTION_BITS),
      .denom    (tally_next),
      .busy     (busy_y),
      .quotient (quo_y)
   );

   always_comb begin
      state_in     = state_ff;
      s1_valid_in  = q_pop;
      last_ok_in   = process && !s1_fe_ff;
      fill_in      = fill_ff;
      sum_col_in   = sum_col_next;
      sum_row_in   = sum_row_next;
      tally_in     = tally_next;
      res_valid_in = res_valid_ff;
      res_count_in = res_count_ff;
      load         = 1'b0;

      if (process) begin
         if (s1_fe_ff) begin
            fill_in = '0;
         end else if (col_next > fill_ff) begin
            fill_in = col_next;
         end
      end

      if (div_start) begin
         res_valid_in = (tally_next != '0) && (tally_next >= min_pixel_count);
         res_count_in = tally_next;
         sum_col_in   = '0;
         sum_row_in   = '0;
         tally_in     = '0;
      end

      unique case (state_ff)
         ST_RUN: begin
            if (div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!busy_x && !busy_y) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in.centroid_x     = !res_valid_ff ? '0 :
                                      (quo_x > COORD_LIM) ? '1 : quo_x[COORD_W-1:0];
         rsp_data_in.centroid_y     = !res_valid_ff ? '0 :
                                      (quo_y > COORD_LIM) ? '1 : quo_y[COORD_W-1:0];
         rsp_data_in.kept_count     = res_count_ff;
         rsp_data_in.centroid_valid = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         s1_valid_ff  <= 1'b0;
         last_ok_ff   <= 1'b0;
         fill_ff      <= '0;
         sum_col_ff   <= '0;
         sum_row_ff   <= '0;
         tally_ff     <= '0;
         res_valid_ff <= 1'b0;
         res_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         last_ok_ff   <= last_ok_in;
         fill_ff      <= fill_in;
         sum_col_ff   <= sum_col_in;
         sum_row_ff   <= sum_row_in;
         tally_ff     <= tally_in;
         res_valid_ff <= res_valid_in;
         res_count_ff <= res_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      last_col_ff <= s1_col_ff;
      last_run_ff <= run_new;
      if (q_pop) begin
         s1_col_ff    <= q_rec[REC_W-1 -: COL_W];
         s1_row_ff    <= q_rec[ROW_W+1:2];
         s1_marked_ff <= q_rec[1];
         s1_fe_ff     <= q_rec[0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/color_mask_vertical_run_centroid.sv]
// Top level of the color mask vertical run centroid block.
//
// Pixels enter as YUV words in raster order on the req_ channel, one word per
// clock when the block does not stall. A pixel is marked when each channel lies
// strictly inside its window; a column whose last 2*HALF_SPAN+1 pixels are all
// marked keeps the pixel HALF_SPAN rows above the current one. On the word that
// carries frame_end, the block sums up the frame and offers one result word on
// the rsp_ channel: the centroid of the kept pixels with FRACTION_BITS fraction
// bits, the kept count and a valid flag.
// Throughput is one pixel per cycle while req_stall is low. After a frame_end word the
// back end takes no word while it divides and hands off the result; the four-word queue
// absorbs the first pixels of the next frame, after which req_stall is raised. The
// frame_end word is popped into the stage register, which starts both divisions, and
// the result word is loaded into the output register once they are done and it is free.
// A result held by rsp_stall stays put; the next frame keeps running until its own
// frame end finds the result register still occupied.
// Reset is synchronous: it loads the default windows, a width of 1024 and a
// minimum count of 1, and starts a fresh frame. The csr_ port is always ready;
// the user must write registers only while the block is idle; it does not enforce this.
module color_mask_vertical_run_centroid #(
   parameter int MAX_WIDTH     = cmvr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = cmvr_pkg::MAX_HEIGHT_DEF,
   parameter int HALF_SPAN     = cmvr_pkg::HALF_SPAN_DEF,
   parameter int FRACTION_BITS = cmvr_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cmvr_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cmvr_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cmvr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cmvr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int REC_W = COL_W + ROW_W + 2;

   // Configuration registers.
   cmvr_pkg::window_type                 win_ff;
   logic [cmvr_pkg::WIDTH_CFG_W-1:0]     image_width_ff;
   logic [cmvr_pkg::TALLY_W-1:0]         min_count_ff;

   // Queue between the front end and the back end.
   logic             q_push;
   logic [REC_W-1:0] q_push_rec;
   logic             q_pop;
   logic [REC_W-1:0] q_pop_rec;
   logic             q_full;
   logic             q_empty;

   assign csr_ready = 1'b1;

   // A write with an index past the register list is taken and ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.luma_low       <= cmvr_pkg::RST_LUMA_LOW;
         win_ff.luma_high      <= cmvr_pkg::RST_LUMA_HIGH;
         win_ff.blue_diff_low  <= cmvr_pkg::RST_BLUE_DIFF_LOW;
         win_ff.blue_diff_high <= cmvr_pkg::RST_BLUE_DIFF_HIGH;
         win_ff.red_diff_low   <= cmvr_pkg::RST_RED_DIFF_LOW;
         win_ff.red_diff_high  <= cmvr_pkg::RST_RED_DIFF_HIGH;
         image_width_ff        <= cmvr_pkg::RST_IMAGE_WIDTH;
         min_count_ff          <= cmvr_pkg::RST_MIN_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cmvr_pkg::CSR_LUMA_LOW:       win_ff.luma_low       <= csr_data[7:0];
            cmvr_pkg::CSR_LUMA_HIGH:      win_ff.luma_high      <= csr_data[7:0];
            cmvr_pkg::CSR_BLUE_DIFF_LOW:  win_ff.blue_diff_low  <= csr_data[7:0];
            cmvr_pkg::CSR_BLUE_DIFF_HIGH: win_ff.blue_diff_high <= csr_data[7:0];
            cmvr_pkg::CSR_RED_DIFF_LOW:   win_ff.red_diff_low   <= csr_data[7:0];
            cmvr_pkg::CSR_RED_DIFF_HIGH:  win_ff.red_diff_high  <= csr_data[7:0];
            cmvr_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[cmvr_pkg::WIDTH_CFG_W-1:0];
            end
            cmvr_pkg::CSR_MIN_COUNT: begin
               min_count_ff <= csr_data[cmvr_pkg::TALLY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The front end stamps each pixel with its column and row and its mark.
   cmvr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .win         (win_ff),
      .image_width (image_width_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_rec       (q_push_rec)
   );

   cmvr_queue #(
      .WIDTH (REC_W),
      .DEPTH (cmvr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_rec),
      .pop       (q_pop),
      .pop_data  (q_pop_rec),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end owns the column run memory, the sums and the divisions.
   cmvr_back #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .HALF_SPAN     (HALF_SPAN),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_rec           (q_pop_rec),
      .q_pop           (q_pop),
      .min_pixel_count (min_count_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

[verif/tb.sv]
// Self-checking testbench for the color mask vertical run centroid block.
`timescale 1ns / 100ps

module tb;
   import cmvr_pkg::*;

   // Clocking and run length. The watchdog is several times the slowest
   // correct run. That run has every random frame at its largest size and a
   // division pass for every frame, all at the worst idle rates.
   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 9;
   localparam int TIMEOUT_NS       = 3_000_000;
   localparam int LONG_HOLD_CYCLES = 600;

   // A frame end keeps the back end busy while it divides and hands off the result.
   // On top of that, up to QUEUE_DEPTH buffered pixels of the next frame still
   // have to drain. This many cycles after the last result, the block is surely idle.
   localparam int SETTLE_CYCLES = SUM_W + FRACTION_BITS_DEF + 4 + QUEUE_DEPTH + 20;

   // Vertical run length that keeps a pixel, and the saturation points.
   localparam int              SPAN      = 2 * HALF_SPAN_DEF + 1;
   localparam longint unsigned SUM_MAX   = (64'd1 << SUM_W) - 1;
   localparam longint unsigned TALLY_MAX = (64'd1 << TALLY_W) - 1;
   localparam longint unsigned COORD_MAX = (64'd1 << COORD_W) - 1;
   localparam int unsigned     MIN_COUNT_TOP = 1048576;

   // Block ports. Every input has a known value from time zero.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Words waiting to be offered, and the frame results that are still due.
   req_type pending_pixels[$];
   rsp_type centroid_expected[$];

   // Idle rates in percent, changed by the stimulus only at falling edges.
   int unsigned req_idle_pct = 33;
   int unsigned rsp_idle_pct = 75;

   // Long receiver hold-off. It is requested by the stimulus and counted in
   // the result monitor.
   bit          hold_rsp_request = 1'b0;
   bit          rsp_hold_taken   = 1'b0;
   int unsigned rsp_hold_left    = 0;

   int unsigned mismatches        = 0;
   int unsigned frames_checked    = 0;
   int unsigned pixels_taken      = 0;
   int unsigned registers_written = 0;

   // Mirror of the register file as the block should see it.
   window_type             pixel_window = '{
      luma_low:       RST_LUMA_LOW,       luma_high:      RST_LUMA_HIGH,
      blue_diff_low:  RST_BLUE_DIFF_LOW,  blue_diff_high: RST_BLUE_DIFF_HIGH,
      red_diff_low:   RST_RED_DIFF_LOW,   red_diff_high:  RST_RED_DIFF_HIGH
   };
   logic [WIDTH_CFG_W-1:0] row_width_reg = RST_IMAGE_WIDTH;
   logic [TALLY_W-1:0]     min_kept_reg  = RST_MIN_COUNT;

   // Frame state of the prediction: per-column run lengths, the scan position
   // and the three accumulators.
   logic [3:0]      run_len [MAX_WIDTH_DEF] = '{default: '0};
   int unsigned     scan_col   = 0;
   int unsigned     scan_row   = 0;
   longint unsigned col_total  = 0;
   longint unsigned row_total  = 0;
   longint unsigned kept_total = 0;

   color_mask_vertical_run_centroid dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // A width register of zero behaves as one column. Anything above the
   // line buffer behaves as the full buffer.
   function automatic int unsigned effective_width();
      if (row_width_reg == 0) return 1;
      if (row_width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return 32'(row_width_reg);
   endfunction

   // Move to the next row once the column runs past the width. The row
   // counter sticks at the last row of the tallest frame.
   function automatic void wrap_column(input int unsigned w);
      if (scan_col >= w) begin
         scan_col = 0;
         if (scan_row < MAX_HEIGHT_DEF - 1) scan_row++;
      end
   endfunction

   function automatic bit strictly_between(input logic [PIX_W-1:0] v, lo, hi);
      return (v > lo) && (v < hi);
   endfunction

   // Mean in fixed point with FRACTION_BITS fraction bits. It is rounded down
   // and clipped to the output width.
   function automatic logic [COORD_W-1:0] scaled_mean(input longint unsigned total,
                                                      input longint unsigned count);
      longint unsigned q;
      if (count == 0) return '0;
      q = (total << FRACTION_BITS_DEF) / count;
      return COORD_W'((q > COORD_MAX) ? COORD_MAX : q);
   endfunction

   // Applies one accepted pixel to the predicted frame state. It returns 1 with
   // the expected result word when the pixel closes a frame.
   function automatic bit take_pixel(input req_type px, output rsp_type frame_result);
      int unsigned w;
      int unsigned run;
      bit          marked;
      bit          good;
      frame_result = '0;
      w = effective_width();

      // A width lowered in the middle of a row sends the scan to a new row
      // before this pixel lands.
      wrap_column(w);

      marked = strictly_between(px.luma, pixel_window.luma_low, pixel_window.luma_high) &&
               strictly_between(px.blue_diff, pixel_window.blue_diff_low,
                                pixel_window.blue_diff_high) &&
               strictly_between(px.red_diff, pixel_window.red_diff_low,
                                pixel_window.red_diff_high);

      run = 32'(run_len[scan_col]);
      if (!marked) run = 0;
      else if (run < SPAN) run++;
      run_len[scan_col] = 4'(run);

      // A full run keeps the pixel HALF_SPAN rows up. The top border rows
      // can never qualify.
      if (run >= SPAN && scan_row >= HALF_SPAN_DEF) begin
         col_total += 64'(scan_col);
         if (col_total > SUM_MAX) col_total = SUM_MAX;
         row_total += 64'(scan_row - HALF_SPAN_DEF);
         if (row_total > SUM_MAX) row_total = SUM_MAX;
         if (kept_total < TALLY_MAX) kept_total++;
      end

      scan_col++;
      wrap_column(w);

      if (!px.frame_end) return 1'b0;

      good = (kept_total != 0) && (kept_total >= min_kept_reg);
      frame_result.centroid_x     = good ? scaled_mean(col_total, kept_total) : '0;
      frame_result.centroid_y     = good ? scaled_mean(row_total, kept_total) : '0;
      frame_result.kept_count     = TALLY_W'(kept_total);
      frame_result.centroid_valid = good;

      run_len    = '{default: '0};
      scan_col   = 0;
      scan_row   = 0;
      col_total  = 0;
      row_total  = 0;
      kept_total = 0;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Pixel driver
   // ------------------------------------------------------------------

   // A word is taken at an edge where valid is high and stall is low. The
   // prediction runs right there, on the word the block saw. A stalled word is
   // held unchanged. Otherwise the next word is offered unless this cycle
   // idles.
   always @(posedge clock) begin : pixel_driver
      rsp_type frame_result;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pixels_taken++;
            if (take_pixel(req_data, frame_result)) centroid_expected.push_back(frame_result);
         end
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Every result word taken is compared with the oldest frame still due.
   // The stall is chosen afresh each cycle from the idle rate. During the one
   // long hold-off it stays high, so the block backs up and stalls its input.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (centroid_expected.size() == 0) begin
               $error("result word with no frame end outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               want = centroid_expected.pop_front();
               check_field("centroid_x", 32'(want.centroid_x), 32'(rsp_data.centroid_x));
               check_field("centroid_y", 32'(want.centroid_y), 32'(rsp_data.centroid_y));
               check_field("kept_count", 32'(want.kept_count), 32'(rsp_data.kept_count));
               check_field("centroid_valid", 32'(want.centroid_valid),
                           32'(rsp_data.centroid_valid));
               frames_checked++;
            end
         end
         if (hold_rsp_request && !rsp_hold_taken) begin
            rsp_hold_taken = 1'b1;
            rsp_hold_left  = LONG_HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Writes one register and then updates the mirror. The caller makes sure
   // the block is idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_LUMA_LOW:       pixel_window.luma_low       = value[PIX_W-1:0];
         CSR_LUMA_HIGH:      pixel_window.luma_high      = value[PIX_W-1:0];
         CSR_BLUE_DIFF_LOW:  pixel_window.blue_diff_low  = value[PIX_W-1:0];
         CSR_BLUE_DIFF_HIGH: pixel_window.blue_diff_high = value[PIX_W-1:0];
         CSR_RED_DIFF_LOW:   pixel_window.red_diff_low   = value[PIX_W-1:0];
         CSR_RED_DIFF_HIGH:  pixel_window.red_diff_high  = value[PIX_W-1:0];
         CSR_IMAGE_WIDTH:    row_width_reg               = value[WIDTH_CFG_W-1:0];
         CSR_MIN_COUNT:      min_kept_reg                = value[TALLY_W-1:0];
         default: ;
      endcase
      registers_written++;
      @(negedge clock);
   endtask

   // Waits until every queued word is in and every result is out. It then
   // lets the back end settle, because trailing pixels may still sit in the
   // block.
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_valid || centroid_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One channel value strictly inside a window. If the window is empty, the
   // random fallback is kept.
   function automatic logic [PIX_W-1:0] inside_window(input logic [PIX_W-1:0] lo, hi,
                                                      input logic [PIX_W-1:0] fallback);
      if (int'(hi) > int'(lo) + 1) return PIX_W'($urandom_range(int'(hi) - 1, int'(lo) + 1));
      return fallback;
   endfunction

   function automatic req_type window_pixel(input bit want_mark);
      req_type px;
      px.luma      = PIX_W'($urandom);
      px.blue_diff = PIX_W'($urandom);
      px.red_diff  = PIX_W'($urandom);
      px.frame_end = 1'b0;
      if (want_mark) begin
         px.luma      = inside_window(pixel_window.luma_low, pixel_window.luma_high, px.luma);
         px.blue_diff = inside_window(pixel_window.blue_diff_low, pixel_window.blue_diff_high,
                                      px.blue_diff);
         px.red_diff  = inside_window(pixel_window.red_diff_low, pixel_window.red_diff_high,
                                      px.red_diff);
      end
      return px;
   endfunction

   // Queues a raster run of pixels in which about mark_pct percent are marked.
   // When end_flag is set, the last pixel of the run closes the frame.
   function automatic void queue_pixels(input int unsigned count, input int unsigned mark_pct,
                                        input bit end_flag);
      req_type px;
      for (int unsigned i = 0; i < count; i++) begin
         px = window_pixel($urandom_range(99) < mark_pct);
         px.frame_end = end_flag && (i == count - 1);
         pending_pixels.push_back(px);
      end
   endfunction

   // Dense marking is needed for 13-high runs to form at all. Lighter rates
   // break runs at random places.
   function automatic int unsigned mark_rate();
      case ($urandom_range(3))
         0:       return 100;
         1:       return 97;
         2:       return 90;
         default: return 75;
      endcase
   endfunction

   // A random window for one channel. It can be the widest window, an empty
   // or inverted one, or an ordinary band of random position and size.
   task automatic write_random_window(input logic [CSR_INDEX_W-1:0] low_index, high_index);
      int unsigned lo;
      int unsigned hi;
      case ($urandom_range(9))
         0: begin
            lo = 0;
            hi = 255;
         end
         1: begin
            lo = $urandom_range(255);
            hi = $urandom_range(lo);
         end
         default: begin
            lo = $urandom_range(200);
            hi = lo + $urandom_range(55, 2);
         end
      endcase
      write_register(low_index, lo);
      write_register(high_index, hi);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // The run has three idle profiles. First the sender idles a third of the
   // time and the receiver three quarters. Then the two rates swap. Last,
   // neither side idles, apart from one long receiver hold-off. Directed frames
   // open the first profile. Every profile then runs random batches with fresh
   // register settings. Registers are only written once the block has drained.
   initial begin : stimulus
      req_type     px;
      int unsigned w;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         req_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 75 : 0;
         rsp_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 33 : 0;

         if (phase == 0) begin
            // Lone frame-end pixels at both extremes of every channel. Nothing
            // is kept, so the centroid is invalid with a zero count.
            pending_pixels.push_back(req_type'{luma: '0, blue_diff: '0, red_diff: '0,
                                               frame_end: 1'b1});
            pending_pixels.push_back(req_type'{luma: '1, blue_diff: '1, red_diff: '1,
                                               frame_end: 1'b1});
            wait_drained();

            // One column. Each of the first six pixels sits exactly on one
            // bound and must stay unmarked. The next fourteen are one step
            // inside, so the last two pixels complete runs and keep two pixels.
            write_register(CSR_IMAGE_WIDTH, 1);
            for (int i = 0; i < 20; i++) begin
               px = window_pixel(1'b1);
               case (i)
                  0: px.luma      = pixel_window.luma_low;
                  1: px.luma      = pixel_window.luma_high;
                  2: px.blue_diff = pixel_window.blue_diff_low;
                  3: px.blue_diff = pixel_window.blue_diff_high;
                  4: px.red_diff  = pixel_window.red_diff_low;
                  5: px.red_diff  = pixel_window.red_diff_high;
                  default: begin
                     px.luma      = (i % 2) ? pixel_window.luma_high - 1'b1
                                            : pixel_window.luma_low + 1'b1;
                     px.blue_diff = (i % 2) ? pixel_window.blue_diff_low + 1'b1
                                            : pixel_window.blue_diff_high - 1'b1;
                     px.red_diff  = (i % 2) ? pixel_window.red_diff_high - 1'b1
                                            : pixel_window.red_diff_low + 1'b1;
                  end
               endcase
               px.frame_end = (i == 19);
               pending_pixels.push_back(px);
            end
            wait_drained();

            // The minimum count is out of reach, so the coordinates read zero
            // while the count is still reported.
            write_register(CSR_MIN_COUNT, (1 << TALLY_W) - 1);
            queue_pixels(20, 100, 1'b1);
            wait_drained();

            // A minimum of zero still gives no valid centroid when nothing is
            // kept.
            write_register(CSR_MIN_COUNT, 0);
            pending_pixels.push_back(req_type'{luma: '0, blue_diff: '0, red_diff: '0,
                                               frame_end: 1'b1});
            wait_drained();

            // A width register of zero acts as a single column.
            write_register(CSR_MIN_COUNT, 1);
            write_register(CSR_IMAGE_WIDTH, 0);
            queue_pixels(16, 100, 1'b1);
            wait_drained();

            // The width is lowered while the scan is at column five. The
            // next pixel must start a new row.
            write_register(CSR_IMAGE_WIDTH, 8);
            queue_pixels(5, 100, 1'b0);
            wait_drained();
            write_register(CSR_IMAGE_WIDTH, 3);
            queue_pixels(3 * 15, 100, 1'b1);
         end

         if (phase == 2) begin
            // Short frames pile up behind a receiver that holds off for a long
            // time. Then the sender pauses until every result is in.
            wait_drained();
            write_register(CSR_IMAGE_WIDTH, 2);
            hold_rsp_request = 1'b1;
            repeat (8) queue_pixels(2 * (SPAN + 1), 100, 1'b1);
            wait_drained();
         end

         repeat (2) begin
            wait_drained();
            write_random_window(CSR_LUMA_LOW, CSR_LUMA_HIGH);
            write_random_window(CSR_BLUE_DIFF_LOW, CSR_BLUE_DIFF_HIGH);
            write_random_window(CSR_RED_DIFF_LOW, CSR_RED_DIFF_HIGH);
            write_register(CSR_IMAGE_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(24, 5)
                                                                     : $urandom_range(3, 1));
            case ($urandom_range(7))
               0:       write_register(CSR_MIN_COUNT, 0);
               1:       write_register(CSR_MIN_COUNT, MIN_COUNT_TOP);
               2:       write_register(CSR_MIN_COUNT, (1 << TALLY_W) - 1);
               default: write_register(CSR_MIN_COUNT, $urandom_range(12));
            endcase

            // Most frames are whole, with tall enough runs to keep pixels.
            // Others end early or mid-row, are pure noise, or stop without a
            // frame end and run on into the next frame.
            w = effective_width();
            repeat (2) begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4, 5: queue_pixels(w * $urandom_range(16, 13), mark_rate(), 1'b1);
                  6:       queue_pixels(w * $urandom_range(24, 17), mark_rate(), 1'b1);
                  7:       queue_pixels($urandom_range(12 * w, 1), mark_rate(), 1'b1);
                  8:       queue_pixels($urandom_range(3 * w, 1), 0, 1'b1);
                  default: queue_pixels($urandom_range(2 * w, 1), mark_rate(), 1'b0);
               endcase
            end
         end
      end

      wait_drained();
      $display("Checked %0d frame results from %0d pixels with %0d register writes,",
               frames_checked, pixels_taken, registers_written);
      $display("under three idle profiles and one long result hold-off.");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
design/cmvr_pkg.sv
design/cmvr_ram.sv
design/cmvr_queue.sv
design/cmvr_divider.sv
design/cmvr_front.sv
design/cmvr_back.sv
design/color_mask_vertical_run_centroid.sv
verif/tb.sv
